// File: hw/rtl/usmg_pkg.sv
// Shared types, constants and helper functions of the UV sphere mesh generator.
package usmg_pkg;

  // Build defaults
  localparam int MAX_LINES_DEF    = 256;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  // Widths of the walk counters and the shared step counter
  localparam int CNT_W     = 9;
  localparam int STEP_W    = 5;
  localparam int DIV_STEPS = 32;

  localparam logic [CNT_W-1:0] LINES_RESET = 9'd16;

  // Fixed-point constants (Q2.30; QUARTER_TURN is a fraction of 2^32 per turn, ONE_Q14 is Q2.14)
  localparam logic signed [33:0] GAIN_INV    = 34'sh026DD3B6A;
  localparam logic        [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic        [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic signed [35:0] ROUND_Q14   = 36'sd32768;
  localparam logic signed [35:0] ONE_Q14     = 36'sd16384;

  // Register indexes on the configuration port
  localparam logic REG_LAT_LINES = 1'b0;
  localparam logic REG_LON_LINES = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_I,
    ST_DIV_J_SET,
    ST_DIV_J,
    ST_ROT_U_SET,
    ST_ROT_U,
    ST_ROT_V_SET,
    ST_ROT_V,
    ST_MUL_X,
    ST_MUL_Y,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              div_load_i;
    logic              div_load_j;
    logic              div_step;
    logic              rot_load_u;
    logic              rot_load_v;
    logic              rot_step;
    logic              mul_x;
    logic              mul_y;
    logic              emit;
    logic [STEP_W-1:0] step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tri_phase;
    logic out_free;
  } ctrl_stat_t;

  // Arctangent of 2^-k in Q2.30
  function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] k);
    logic signed [33:0] a;
    case (k)
      5'd0:    a = 34'sh03243F6A8;
      5'd1:    a = 34'sh01DAC6705;
      5'd2:    a = 34'sh00FADBAFC;
      5'd3:    a = 34'sh007F56EA6;
      5'd4:    a = 34'sh003FEAB76;
      5'd5:    a = 34'sh001FFD55B;
      5'd6:    a = 34'sh000FFFAAA;
      5'd7:    a = 34'sh0007FFF55;
      5'd8:    a = 34'sh0003FFFEA;
      5'd9:    a = 34'sh0001FFFFD;
      5'd10:   a = 34'sh0000FFFFF;
      5'd11:   a = 34'sh00007FFFF;
      5'd12:   a = 34'sh00003FFFF;
      5'd13:   a = 34'sh00001FFFF;
      5'd14:   a = 34'sh00000FFFF;
      5'd15:   a = 34'sh000007FFF;
      5'd16:   a = 34'sh000003FFF;
      5'd17:   a = 34'sh000001FFF;
      5'd18:   a = 34'sh000000FFF;
      5'd19:   a = 34'sh0000007FF;
      5'd20:   a = 34'sh0000003FF;
      5'd21:   a = 34'sh0000001FF;
      5'd22:   a = 34'sh0000000FF;
      5'd23:   a = 34'sh00000007F;
      default: a = 34'sh000000000;
    endcase
    return a;
  endfunction

  // Q2.30 to Q2.14 with rounding and clamp to [-1, 1]
  function automatic logic [15:0] to_q14(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + ROUND_Q14) >>> 16;
    if (t > ONE_Q14) t = ONE_Q14;
    if (t < -ONE_Q14) t = -ONE_Q14;
    return t[15:0];
  endfunction

endpackage

// File: hw/rtl/usmg_ctrl.sv
// Controller state machine: sequences division, rotation, multiply and emit steps.
module usmg_ctrl #(
  parameter int CORDIC_STEPS = usmg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_advance,
  output logic                  in_ready,
  input  usmg_pkg::ctrl_stat_t  stat,
  output usmg_pkg::ctrl_cmd_t   cmd
);
  import usmg_pkg::*;

  localparam int ROT_N = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(ROT_N - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Hold state and step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.step  = step_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_advance) begin
          if (stat.tri_phase) begin
            state_nxt = ST_EMIT;
          end else begin
            cmd.div_load_i = 1'b1;
            step_nxt       = '0;
            state_nxt      = ST_DIV_I;
          end
        end
      end
      ST_DIV_I: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) state_nxt = ST_DIV_J_SET;
      end
      ST_DIV_J_SET: begin
        cmd.div_load_j = 1'b1;
        step_nxt       = '0;
        state_nxt      = ST_DIV_J;
      end
      ST_DIV_J: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) state_nxt = ST_ROT_U_SET;
      end
      ST_ROT_U_SET: begin
        cmd.rot_load_u = 1'b1;
        step_nxt       = '0;
        state_nxt      = ST_ROT_U;
      end
      ST_ROT_U: begin
        cmd.rot_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == ROT_LAST) state_nxt = ST_ROT_V_SET;
      end
      ST_ROT_V_SET: begin
        cmd.rot_load_v = 1'b1;
        step_nxt       = '0;
        state_nxt      = ST_ROT_V;
      end
      ST_ROT_V: begin
        cmd.rot_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == ROT_LAST) state_nxt = ST_MUL_X;
      end
      ST_MUL_X: begin
        cmd.mul_x = 1'b1;
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/usmg_dp.sv
// Datapath: walk counters, angle divider, CORDIC, multiplier and output register.
module usmg_dp #(
  parameter int MAX_LINES = usmg_pkg::MAX_LINES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  usmg_pkg::ctrl_cmd_t         cmd,
  output usmg_pkg::ctrl_stat_t        stat,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [usmg_pkg::CNT_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_triangle,
  output logic [15:0]                 out_pos_x,
  output logic [15:0]                 out_pos_y,
  output logic [15:0]                 out_pos_z,
  output logic [15:0]                 out_tex_s,
  output logic [15:0]                 out_tex_t,
  output logic [15:0]                 out_corner_a,
  output logic [15:0]                 out_corner_b,
  output logic [15:0]                 out_corner_c,
  output logic                        out_last
);
  import usmg_pkg::*;

  // Configuration and walk state
  logic [CNT_W-1:0] lat_r, lon_r;
  logic [CNT_W-1:0] stacks, sectors;
  logic             phase_r, half_r;
  logic [CNT_W-1:0] stack_r, sector_r;

  // Divider
  logic [CNT_W:0]   rem_r;
  logic [32:0]      q_r, q_i_r;
  logic             div_j_r;
  logic [CNT_W-1:0] div_n, div_d;
  logic [CNT_W:0]   rem2;
  logic             qbit;

  // CORDIC
  logic signed [33:0] x_r, y_r, z_r;
  logic [1:0]         quad_r;
  logic [31:0]        turn;
  logic [60:0]        zprod;
  logic signed [33:0] xs, ys, at;
  logic signed [31:0] cq, sq;
  logic signed [31:0] cu_r, su_r, sv_r;
  logic signed [63:0] prod_r;
  logic [15:0]        pos_x_r, tex_s_r, tex_t_r;

  // Output register
  logic        out_valid_r, is_tri_r, last_r;
  logic [15:0] o_px_r, o_py_r, o_pz_r, o_ts_r, o_tt_r, o_ca_r, o_cb_r, o_cc_r;

  // Walk next values
  logic [CNT_W:0]   v_se, v_st;
  logic [19:0]      k1, k2;
  logic [CNT_W:0]   t_st, t_se;
  logic             t_h, t_done, t_last;

  // Saturated stack and sector counts
  function automatic logic [CNT_W-1:0] count_from(input logic [CNT_W-1:0] r);
    logic [CNT_W-1:0] n;
    n = (32'(r) > MAX_LINES) ? CNT_W'(MAX_LINES) : r;
    return (n > 1) ? n - 1'b1 : CNT_W'(1);
  endfunction

  assign stacks  = count_from(lat_r);
  assign sectors = count_from(lon_r);

  assign stat.tri_phase = phase_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  // Divider operand select and one restoring step; the stack division uses
  // stacks, the sector division uses sectors
  always_comb begin
    div_n = cmd.div_load_j ? sector_r : stack_r;
    div_d = (cmd.div_load_j || (div_j_r && !cmd.div_load_i)) ? sectors : stacks;
    rem2  = {rem_r[CNT_W-1:0], 1'b0};
    qbit  = 1'b0;
  end

  // Quadrant correction of the CORDIC result
  always_comb begin
    case (quad_r)
      2'd0:    begin cq =  x_r[31:0]; sq =  y_r[31:0]; end
      2'd1:    begin cq = -y_r[31:0]; sq =  x_r[31:0]; end
      2'd2:    begin cq = -x_r[31:0]; sq = -y_r[31:0]; end
      default: begin cq =  y_r[31:0]; sq = -x_r[31:0]; end
    endcase
  end

  // Angle to radians and one rotation step
  always_comb begin
    turn  = cmd.rot_load_v ? q_r[31:0] : (QUARTER_TURN - q_i_r[32:1]);
    zprod = 61'(turn[29:0]) * 61'(HALF_PI_Q30);
    xs    = x_r >>> cmd.step;
    ys    = y_r >>> cmd.step;
    at    = atan_q30(cmd.step);
  end

  // Vertex walk advance
  always_comb begin
    v_se = {1'b0, sector_r} + 1'b1;
    v_st = {1'b0, stack_r} + 1'b1;
  end

  // Triangle corners and the next emitted half
  always_comb begin
    k1 = 20'(stack_r) * 20'(sectors) + 20'(stack_r) + 20'(sector_r);
    k2 = k1 + 20'(sectors) + 20'd1;
    t_st   = {1'b0, stack_r};
    t_se   = {1'b0, sector_r};
    t_h    = half_r;
    t_done = 1'b0;
    t_last = 1'b0;
    for (int it = 0; it < 2; it++) begin
      if (!t_done) begin
        if (t_h) begin
          t_h  = 1'b0;
          t_se = t_se + 1'b1;
          if (t_se >= {1'b0, sectors}) begin
            t_se = '0;
            t_st = t_st + 1'b1;
          end
        end else begin
          t_h = 1'b1;
        end
        if (t_st >= {1'b0, stacks}) begin
          t_last = 1'b1;
          t_done = 1'b1;
        end else if (!t_h) begin
          t_done = (t_st != '0);
        end else begin
          t_done = (t_st != {1'b0, stacks - 1'b1});
        end
      end
    end
  end

  // Configuration registers and walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r    <= LINES_RESET;
      lon_r    <= LINES_RESET;
      phase_r  <= 1'b0;
      half_r   <= 1'b0;
      stack_r  <= '0;
      sector_r <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_LAT_LINES) lat_r <= cfg_wdata;
      else lon_r <= cfg_wdata;
      phase_r  <= 1'b0;
      half_r   <= 1'b0;
      stack_r  <= '0;
      sector_r <= '0;
    end else if (cmd.emit) begin
      if (!phase_r) begin
        if (v_se > {1'b0, sectors}) begin
          sector_r <= '0;
          if (v_st > {1'b0, stacks}) begin
            stack_r <= '0;
            if (stacks >= 2) begin
              phase_r <= 1'b1;
              half_r  <= 1'b1;
            end
          end else begin
            stack_r <= v_st[CNT_W-1:0];
          end
        end else begin
          sector_r <= v_se[CNT_W-1:0];
        end
      end else if (t_last) begin
        phase_r  <= 1'b0;
        half_r   <= 1'b0;
        stack_r  <= '0;
        sector_r <= '0;
      end else begin
        half_r   <= t_h;
        stack_r  <= t_st[CNT_W-1:0];
        sector_r <= t_se[CNT_W-1:0];
      end
    end
  end

  // Divider: (n << 32) / d, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load_i || cmd.div_load_j) begin
      div_j_r <= cmd.div_load_j;
      if (cmd.div_load_j) q_i_r <= q_r;
      if (div_n >= div_d) begin
        rem_r <= {1'b0, div_n - div_d};
        q_r   <= {1'b1, 32'd0};
      end else begin
        rem_r <= {1'b0, div_n};
        q_r   <= '0;
      end
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, div_d}) begin
        rem_r <= rem2 - {1'b0, div_d};
        q_r   <= {q_r[32], q_r[30:0], 1'b1};
      end else begin
        rem_r <= rem2;
        q_r   <= {q_r[32], q_r[30:0], qbit};
      end
    end
  end

  // CORDIC rotation and products
  always_ff @(posedge clk) begin
    if (cmd.rot_load_u || cmd.rot_load_v) begin
      x_r    <= GAIN_INV;
      y_r    <= '0;
      z_r    <= $signed({3'b000, zprod[60:30]});
      quad_r <= turn[31:30];
      if (cmd.rot_load_v) begin
        cu_r    <= cq;
        su_r    <= sq;
        tex_t_r <= q_i_r[32:17];
        tex_s_r <= q_r[32:17];
      end
    end else if (cmd.rot_step) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (cmd.mul_x) begin
      prod_r <= cu_r * cq;
      sv_r   <= sq;
    end
    if (cmd.mul_y) begin
      pos_x_r <= to_q14(36'(prod_r >>> 30));
      prod_r  <= cu_r * sv_r;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      is_tri_r <= phase_r;
      if (!phase_r) begin
        o_px_r <= pos_x_r;
        o_py_r <= to_q14(36'(prod_r >>> 30));
        o_pz_r <= to_q14(36'(su_r));
        o_ts_r <= tex_s_r;
        o_tt_r <= tex_t_r;
        o_ca_r <= '0;
        o_cb_r <= '0;
        o_cc_r <= '0;
        last_r <= (v_se > {1'b0, sectors}) && (v_st > {1'b0, stacks}) && (stacks < 2);
      end else begin
        o_px_r <= '0;
        o_py_r <= '0;
        o_pz_r <= '0;
        o_ts_r <= '0;
        o_tt_r <= '0;
        o_ca_r <= half_r ? k1[15:0] + 16'd1 : k1[15:0];
        o_cb_r <= k2[15:0];
        o_cc_r <= half_r ? k2[15:0] + 16'd1 : k1[15:0] + 16'd1;
        last_r <= t_last;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_triangle = is_tri_r;
  assign out_pos_x       = o_px_r;
  assign out_pos_y       = o_py_r;
  assign out_pos_z       = o_pz_r;
  assign out_tex_s       = o_ts_r;
  assign out_tex_t       = o_tt_r;
  assign out_corner_a    = o_ca_r;
  assign out_corner_b    = o_cb_r;
  assign out_corner_c    = o_cc_r;
  assign out_last        = last_r;

endmodule

// File: hw/rtl/uv_sphere_mesh_generator.sv
// UV sphere mesh generator: one vertex or triangle request in, one record out.
// Each request with advance set yields one record. A vertex record takes two
// 32-step restoring divisions for the stack and sector angles and texture
// coordinates, two rotations of CORDIC_STEPS steps, capped at ATAN_ENTRIES,
// through one shared CORDIC unit, and two passes through one 32x32 multiplier.
// The result sits in an output register, so a new request is taken while the
// previous record waits. Writing lat_lines or lon_lines restarts the walk at
// the first vertex.
module uv_sphere_mesh_generator #(
  parameter int MAX_LINES    = usmg_pkg::MAX_LINES_DEF,
  parameter int CORDIC_STEPS = usmg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [0] advance
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [127:0]                out_tdata,  // pos_x, pos_y, pos_z, tex_s, tex_t,
                                                  // corner_a, corner_b, corner_c
  output logic                        out_tuser,  // [0] is_triangle
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [usmg_pkg::CNT_W-1:0]  cfg_wdata
);
  import usmg_pkg::*;

  ctrl_cmd_t   cmd;
  ctrl_stat_t  stat;
  logic [15:0] pos_x, pos_y, pos_z, tex_s, tex_t, corner_a, corner_b, corner_c;

  usmg_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_advance(in_tdata[0]),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  usmg_dp #(
    .MAX_LINES(MAX_LINES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_is_triangle(out_tuser),
    .out_pos_x      (pos_x),
    .out_pos_y      (pos_y),
    .out_pos_z      (pos_z),
    .out_tex_s      (tex_s),
    .out_tex_t      (tex_t),
    .out_corner_a   (corner_a),
    .out_corner_b   (corner_b),
    .out_corner_c   (corner_c),
    .out_last       (out_tlast)
  );

  // Pack result fields, first field lowest
  assign out_tdata = {corner_c, corner_b, corner_a, tex_t, tex_s, pos_z, pos_y, pos_x};

endmodule

// File: tb/sv/tb_uv_sphere_mesh_generator.sv
// Self-checking testbench of the UV sphere mesh generator: random requests and stalls, scoreboard.
`timescale 1ns / 1ps

module tb_uv_sphere_mesh_generator;
  import usmg_pkg::*;

  localparam int MAX_CYCLES = 3000000;

  typedef struct packed {
    logic              is_tri;
    logic signed [15:0] px, py, pz;
    logic [15:0]       ts, tt, ca, cb, cc;
    logic              last;
  } mesh_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic cfg_addr = REG_LAT_LINES;
  logic [CNT_W-1:0] cfg_wdata = '0;

  uv_sphere_mesh_generator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Walk state of the predictor
  logic [8:0] lat_reg, lon_reg;
  bit tri_ph, half;
  int unsigned stk, sec;

  logic [7:0] pending_req[$];
  mesh_rec_t expected_rec[$];
  int mismatches = 0;
  int unsigned cycle = 0;
  bit calm = 0;
  bit hold_sender = 0;
  bit in_acc = 0;

  localparam longint ATAN_TAB[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  function automatic int unsigned mesh_count(logic [8:0] r);
    int unsigned n;
    n = (r > 256) ? 256 : r;
    return (n > 1) ? n - 1 : 1;
  endfunction

  // Arithmetic shift is a floor shift on signed values
  function automatic void turn_sincos(logic [31:0] turn, output longint c, output longint s);
    longint x, y, z, nx;
    x = 64'h26DD3B6A;
    y = 0;
    z = longint'((64'(turn[29:0]) * 64'd1686629713) >> 30);
    for (int k = 0; k < 16; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k); y = y + (x >>> k); z -= ATAN_TAB[k];
      end else begin
        nx = x + (y >>> k); y = y - (x >>> k); z += ATAN_TAB[k];
      end
      x = nx;
    end
    case (turn[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [15:0] q14_of(longint v);
    longint q;
    q = (v + 32768) >>> 16;
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[15:0];
  endfunction

  function automatic void walk_restart();
    tri_ph = 0; stk = 0; sec = 0; half = 0;
  endfunction

  // Compute the record one advance request yields and step the walk
  function automatic mesh_rec_t next_record();
    mesh_rec_t r;
    int unsigned stacks, sectors, k1, k2;
    logic [31:0] pu, pv;
    longint cu, su, cv, sv;
    bit ok;
    stacks = mesh_count(lat_reg);
    sectors = mesh_count(lon_reg);
    r = '0;
    if (stk > stacks || sec > sectors) walk_restart();
    if (tri_ph && (stacks < 2 || stk >= stacks)) walk_restart();
    if (!tri_ph) begin
      pu = 32'h4000_0000 - 32'((64'(stk) << 31) / stacks);
      pv = 32'((64'(sec) << 32) / sectors);
      turn_sincos(pu, cu, su);
      turn_sincos(pv, cv, sv);
      r.px = q14_of((cu * cv) >>> 30);
      r.py = q14_of((cu * sv) >>> 30);
      r.pz = q14_of(su);
      r.ts = 16'(64'(sec) * 32768 / sectors);
      r.tt = 16'(64'(stk) * 32768 / stacks);
      sec++;
      if (sec > sectors) begin
        sec = 0;
        stk++;
        if (stk > stacks) begin
          if (stacks >= 2) begin
            tri_ph = 1; stk = 0; sec = 0; half = 1;
          end else begin
            r.last = 1;
            walk_restart();
          end
        end
      end
    end else begin
      k1 = stk * (sectors + 1) + sec;
      k2 = k1 + sectors + 1;
      r.is_tri = 1;
      if (!half) begin
        r.ca = 16'(k1); r.cb = 16'(k2); r.cc = 16'(k1 + 1);
      end else begin
        r.ca = 16'(k1 + 1); r.cb = 16'(k2); r.cc = 16'(k2 + 1);
      end
      ok = 0;
      while (!ok) begin
        if (half) begin
          half = 0;
          sec++;
          if (sec >= sectors) begin
            sec = 0; stk++;
          end
        end else half = 1;
        if (stk >= stacks) begin
          r.last = 1;
          walk_restart();
          ok = 1;
        end else if (!half) ok = (stk != 0);
        else ok = (stk != stacks - 1);
      end
    end
    return r;
  endfunction

  // Append one request to the pending queue
  function automatic void add_req(logic [7:0] req);
    pending_req = {pending_req, req};
  endfunction

  // Driver: present requests on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_acc) begin
        // hold the request
      end else if (pending_req.size() > 0 && !hold_sender
                   && (calm || $urandom_range(99) >= 38)) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_req.pop_front();
      end else begin
        in_tvalid <= 1'b0;
        in_tdata <= 8'($urandom_range(255) & 8'hFE);
      end
      out_tready <= calm || ($urandom_range(99) >= 38);
    end
  end

  // Monitor: predict on accepted requests, check accepted records
  always @(posedge clk) begin
    mesh_rec_t got, exp_r;
    cycle <= cycle + 1;
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready && in_tdata[0])
      expected_rec = {expected_rec, next_record()};
    if (rst_n && out_tvalid && out_tready) begin
      got.is_tri = out_tuser;
      {got.cc, got.cb, got.ca, got.tt, got.ts, got.pz, got.py, got.px} = out_tdata;
      got.last = out_tlast;
      if (expected_rec.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record %h", got);
      end else begin
        exp_r = expected_rec.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  // Write one register while the block is idle
  task automatic write_reg(logic idx, logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LAT_LINES) lat_reg = val; else lon_reg = val;
    walk_restart();
  endtask

  task automatic drain();
    while (pending_req.size() > 0 || in_tvalid || expected_rec.size() > 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic queue_reqs(int n);
    for (int k = 0; k < n; k++)
      add_req(($urandom_range(3) == 0) ? 8'($urandom_range(255) & 8'hFE)
                                       : 8'($urandom_range(255) | 8'h01));
  endtask

  initial begin
    int lat_set[10] = '{2, 3, 0, 1, 4, 5, 256, 3, 511, 6};
    int lon_set[10] = '{2, 0, 3, 256, 1, 4, 2, 511, 3, 5};
    lat_reg = LINES_RESET;
    lon_reg = LINES_RESET;
    walk_restart();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    // Directed: a small 3x3 mesh, advance requests with the other bits all set or all clear
    write_reg(REG_LAT_LINES, 9'd3);
    write_reg(REG_LON_LINES, 9'd3);
    for (int k = 0; k < 20; k++) add_req(8'hFF ^ (8'(k[0]) ? 8'h00 : 8'hFE));
    calm = 1;
    drain();
    calm = 0;
    // Random phases over several geometries; phase 3 with a sender pause
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_LAT_LINES, 9'(lat_set[p]));
      write_reg(REG_LON_LINES, 9'(lon_set[p]));
      queue_reqs(p == 6 ? 60 : 97);
      if (p == 3) begin
        while (pending_req.size() > 60) @(negedge clk);
        hold_sender = 1;
        while (in_tvalid || expected_rec.size() > 0) @(negedge clk);
        hold_sender = 0;
      end
      drain();
    end
    if (mismatches == 0 && expected_rec.size() == 0)
      $display("uv_sphere_mesh_generator regression: pass");
    else
      $display("uv_sphere_mesh_generator regression: fail");
    $finish;
  end

  // Run limit
  always @(posedge clk) begin
    if (cycle >= MAX_CYCLES) begin
      $display("uv_sphere_mesh_generator regression: fail");
      $finish;
    end
  end

endmodule
